// ===== rtl/stm_pkg.sv =====
// Package for the sensor timestamp matcher: payload structs, register indexes,
// request codes and controller/datapath command types. No dependencies.
package stm_pkg;

  localparam int TimeBits       = 40;
  localparam int EntriesDefault = 16;
  localparam int SensorCount    = 5;
  localparam int SidBits        = 3;

  // request codes
  localparam logic [1:0] REQ_ARRIVAL = 2'd0;
  localparam logic [1:0] REQ_TICK    = 2'd1;
  localparam logic [1:0] REQ_SAVE    = 2'd2;

  // register indexes
  localparam logic [1:0] REG_WINDOW = 2'd0;
  localparam logic [1:0] REG_HOLD   = 2'd1;
  localparam logic [1:0] REG_PANO   = 2'd2;

  // sensor ids
  localparam logic [2:0] SID_MASTER = 3'd0;
  localparam logic [2:0] SID_CAM_A  = 3'd1;
  localparam logic [2:0] SID_PANO0  = 3'd2;
  localparam logic [2:0] SID_PANO1  = 3'd3;
  localparam logic [2:0] SID_CAM_B  = 3'd4;

  typedef struct packed {
    logic [1:0]          req_type;
    logic [2:0]          sensor_id;
    logic [TimeBits-1:0] frame_time;
    logic                frame_valid;
    logic [TimeBits-1:0] now_time;
  } in_item_t;

  typedef struct packed {
    logic                master_found;
    logic [TimeBits-1:0] master_time;
    logic                any_match;
    logic                save_now;
    logic                cam_a_found;
    logic [TimeBits-1:0] cam_a_time;
    logic                pano0_found;
    logic [TimeBits-1:0] pano0_time;
    logic                pano1_found;
    logic [TimeBits-1:0] pano1_time;
    logic                cam_b_found;
    logic [TimeBits-1:0] cam_b_time;
  } out_item_t;

  // datapath scan phases
  localparam logic [2:0] PH_ARRIVE = 3'd0;
  localparam logic [2:0] PH_AGE    = 3'd1;
  localparam logic [2:0] PH_MASTER = 3'd2;
  localparam logic [2:0] PH_MATCH  = 3'd3;
  localparam logic [2:0] PH_PURGE  = 3'd4;

  // controller to datapath
  typedef struct packed {
    logic       load;     // capture input item
    logic       start;    // begin a sweep
    logic [2:0] phase;    // which sweep
    logic       clr_res;  // clear result accumulators
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic done;       // sweep finished
    logic mfound;     // master store not empty
    logic any;        // some secondary matched
  } dp_stat_t;

endpackage

// ===== rtl/stm_datapath.sv =====
// Datapath of the sensor timestamp matcher: slot store, occupied bits and the
// one-slot-per-cycle scan unit. Depends on stm_pkg.
module stm_datapath #(
  parameter int ENTRIES_PER_SENSOR = stm_pkg::EntriesDefault
) (
  input  logic               clk,
  input  logic               rst,
  input  stm_pkg::dp_cmd_t   cmd,
  output stm_pkg::dp_stat_t  stat,
  input  stm_pkg::in_item_t  item,
  input  logic [19:0]        match_window,
  input  logic [25:0]        hold_time,
  input  logic [1:0]         pano_count,
  input  logic               save_pending,
  output stm_pkg::out_item_t result
);
  localparam int TimeBits = stm_pkg::TimeBits;
  localparam int Slots    = stm_pkg::SensorCount * ENTRIES_PER_SENSOR;
  localparam int SlotBits = $clog2(Slots);

  // store: time and valid flag, one memory; occupancy in flip-flops
  logic [TimeBits:0] mem [Slots];
  logic [Slots-1:0]  occ;

  logic [2:0]            sid;
  logic [TimeBits-1:0]   ftime;
  logic                  fvalid;
  logic [TimeBits-1:0]   now;

  logic [SlotBits-1:0]   ptr;       // slot being read
  logic                  busy;
  logic                  done;
  logic                  rd_ok;     // read data for slot rd_ptr is valid
  logic [SlotBits-1:0]   rd_ptr;
  logic [TimeBits:0]     rd_data;
  logic [2:0]            phase;

  logic                  mfound;
  logic [TimeBits-1:0]   mtime;
  logic [3:0]            found;
  logic [TimeBits-1:0]   best [4];
  logic [TimeBits-1:0]   bestd [4];

  // store activity
  function automatic logic active(input logic [2:0] s, input logic [1:0] pc);
    logic r;
    r = 1'b0;
    case (s)
      stm_pkg::SID_MASTER, stm_pkg::SID_CAM_A, stm_pkg::SID_CAM_B: r = 1'b1;
      stm_pkg::SID_PANO0: r = (pc != 2'd0);
      stm_pkg::SID_PANO1: r = pc[1] | (pc == 2'd3);
      default: r = 1'b0;
    endcase
    return r;
  endfunction

  // sensor of the slot under read
  logic [2:0]          rsid;
  logic [TimeBits-1:0] rt;
  logic                rv;
  logic [TimeBits:0]   cutoff_w;
  logic                age_en;
  logic [TimeBits-1:0] gap;
  logic [1:0]          si;
  always_comb begin
    rsid = stm_pkg::SID_MASTER;
    for (int s = 1; s < stm_pkg::SensorCount; s++) begin
      if (32'(rd_ptr) >= s * ENTRIES_PER_SENSOR) rsid = 3'(s);
    end
    rt   = rd_data[TimeBits:1];
    rv   = rd_data[0];
    cutoff_w = {1'b0, now} - (TimeBits+1)'(hold_time);
    age_en   = !cutoff_w[TimeBits];
    gap      = (rt >= mtime) ? rt - mtime : mtime - rt;
    si       = 2'(rsid - 3'd1);
  end

  // lowest free slot of the arriving sensor's row
  logic                  free_hit;
  logic [SlotBits-1:0]   free_slot;
  always_comb begin
    free_hit  = 1'b0;
    free_slot = '0;
    for (int i = ENTRIES_PER_SENSOR - 1; i >= 0; i--) begin
      if (!occ[32'(sid) * ENTRIES_PER_SENSOR + i]) begin
        free_hit  = 1'b1;
        free_slot = SlotBits'(32'(sid) * ENTRIES_PER_SENSOR + i);
      end
    end
  end

  // memory write and registered read
  always_ff @(posedge clk) begin
    if (busy && phase == stm_pkg::PH_ARRIVE && free_hit && sid < stm_pkg::SID_CAM_B + 3'd1
        && active(sid, pano_count))
      mem[free_slot] <= {ftime, fvalid};
    rd_data <= mem[ptr];
  end

  // sweep control and accumulators
  always_ff @(posedge clk) begin
    if (rst) begin
      occ   <= '0;
      busy  <= 1'b0;
      rd_ok <= 1'b0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      if (cmd.load) begin
        sid    <= item.sensor_id;
        ftime  <= item.frame_time;
        fvalid <= item.frame_valid;
        now    <= item.now_time;
      end
      if (cmd.clr_res) begin
        mfound <= 1'b0;
        mtime  <= '0;
        found  <= '0;
        for (int k = 0; k < 4; k++) begin
          best[k]  <= '0;
          bestd[k] <= '0;
        end
      end
      if (cmd.start) begin
        busy  <= 1'b1;
        phase <= cmd.phase;
        ptr   <= '0;
        rd_ok <= 1'b0;
      end else if (busy) begin
        if (phase == stm_pkg::PH_ARRIVE) begin
          if (free_hit && sid <= stm_pkg::SID_CAM_B && active(sid, pano_count))
            occ[free_slot] <= 1'b1;
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          rd_ok  <= 1'b1;
          rd_ptr <= ptr;
          if (ptr != SlotBits'(Slots - 1)) ptr <= ptr + SlotBits'(1);
          if (rd_ok) begin
            if (occ[rd_ptr]) begin
              case (phase)
                stm_pkg::PH_AGE: begin
                  if (age_en && active(rsid, pano_count) && rt < cutoff_w[TimeBits-1:0])
                    occ[rd_ptr] <= 1'b0;
                end
                stm_pkg::PH_MASTER: begin
                  if (rsid == stm_pkg::SID_MASTER && (!mfound || rt > mtime)) begin
                    mfound <= 1'b1;
                    mtime  <= rt;
                  end
                end
                stm_pkg::PH_MATCH: begin
                  if (rsid != stm_pkg::SID_MASTER && active(rsid, pano_count)
                      && (rsid == stm_pkg::SID_CAM_A || rv)
                      && gap <= TimeBits'(match_window)
                      && (!found[si] || gap < bestd[si])) begin
                    found[si] <= 1'b1;
                    bestd[si] <= gap;
                    best[si]  <= rt;
                  end
                end
                stm_pkg::PH_PURGE: begin
                  if (rsid == stm_pkg::SID_MASTER) begin
                    if (rt <= mtime) occ[rd_ptr] <= 1'b0;
                  end else if (found[si] && rt <= best[si]) begin
                    occ[rd_ptr] <= 1'b0;
                  end
                end
                default: ;
              endcase
            end
            if (rd_ptr == SlotBits'(Slots - 1)) begin
              busy  <= 1'b0;
              rd_ok <= 1'b0;
              done  <= 1'b1;
            end
          end
        end
      end
    end
  end

  always_comb begin
    stat.done   = done;
    stat.mfound = mfound;
    stat.any    = |found;
    result.master_found = mfound;
    result.master_time  = mtime;
    result.any_match    = |found;
    result.save_now     = (|found) & save_pending;
    result.cam_a_found  = found[0];
    result.cam_a_time   = found[0] ? best[0] : '0;
    result.pano0_found  = found[1];
    result.pano0_time   = found[1] ? best[1] : '0;
    result.pano1_found  = found[2];
    result.pano1_time   = found[2] ? best[2] : '0;
    result.cam_b_found  = found[3];
    result.cam_b_time   = found[3] ? best[3] : '0;
  end

endmodule

// ===== rtl/stm_ctrl.sv =====
// Controller of the sensor timestamp matcher: sequences the sweeps of one
// item and owns the handshakes. Depends on stm_pkg.
module stm_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        in_req,
  output logic              out_valid,
  input  logic              out_ready,
  output stm_pkg::dp_cmd_t  cmd,
  input  stm_pkg::dp_stat_t stat,
  output logic              save_pending
);
  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_ARRIVE = 3'd1;
  localparam logic [2:0] S_AGE    = 3'd2;
  localparam logic [2:0] S_MASTER = 3'd3;
  localparam logic [2:0] S_MATCH  = 3'd4;
  localparam logic [2:0] S_PURGE  = 3'd5;
  localparam logic [2:0] S_OUT    = 3'd6;

  logic [2:0] state, state_next;
  logic       started, started_next;
  logic       save_next, out_valid_next;

  // a held result does not block input; only the next result waits for it
  assign in_ready = (state == S_IDLE);

  // next state and sweep commands
  always_comb begin
    state_next     = state;
    started_next   = started;
    save_next      = save_pending;
    out_valid_next = out_valid && !out_ready;
    cmd            = '0;
    case (state)
      S_IDLE: begin
        if (in_valid && in_ready) begin
          cmd.load    = 1'b1;
          cmd.clr_res = 1'b1;
          started_next = 1'b0;
          case (in_req)
            stm_pkg::REQ_ARRIVAL: state_next = S_ARRIVE;
            stm_pkg::REQ_TICK:    state_next = S_AGE;
            stm_pkg::REQ_SAVE:    save_next  = 1'b1;
            default: ;
          endcase
        end
      end
      S_ARRIVE, S_AGE, S_MASTER, S_MATCH, S_PURGE: begin
        if (!started) begin
          cmd.start    = 1'b1;
          started_next = 1'b1;
          case (state)
            S_ARRIVE: cmd.phase = stm_pkg::PH_ARRIVE;
            S_AGE:    cmd.phase = stm_pkg::PH_AGE;
            S_MASTER: cmd.phase = stm_pkg::PH_MASTER;
            S_MATCH:  cmd.phase = stm_pkg::PH_MATCH;
            default:  cmd.phase = stm_pkg::PH_PURGE;
          endcase
        end else if (stat.done) begin
          started_next = 1'b0;
          case (state)
            S_ARRIVE: state_next = S_IDLE;
            S_AGE:    state_next = S_MASTER;
            S_MASTER: state_next = stat.mfound ? S_MATCH : S_OUT;
            S_MATCH:  state_next = stat.any ? S_PURGE : S_OUT;
            default:  state_next = S_OUT;
          endcase
        end
      end
      S_OUT: begin
        // wait here while the previous result is still held
        if (!out_valid || out_ready) begin
          out_valid_next = 1'b1;
          state_next     = S_IDLE;
          if (stat.any) save_next = 1'b0;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      started      <= 1'b0;
      save_pending <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      state        <= state_next;
      started      <= started_next;
      save_pending <= save_next;
      out_valid    <= out_valid_next;
    end
  end

endmodule

// ===== rtl/sensor_timestamp_matcher.sv =====
// Top level of the sensor timestamp matcher: configuration registers,
// controller and datapath. Depends on stm_pkg, stm_ctrl, stm_datapath.
//
// Usage: input items (arrival, sync tick, save trigger) come on in_valid /
// in_ready with payload in_item; one result per sync tick leaves on
// out_valid / out_ready with payload out_item. Registers are written on
// cfg_valid / cfg_ready (always ready), index cfg_index, data cfg_data.
// A tick sweeps the store of 5*ENTRIES_PER_SENSOR slots one slot per cycle
// through the single memory read port, up to four sweeps (age, master, match,
// purge); after the last sweep the controller enters its output state and
// loads the result register once no earlier result is held. One item is
// handled at a time; in_ready is low while an item is at work. A stalled
// receiver holds the result in the output register; input is still taken,
// and the next tick waits at its result until the held one leaves.
// Reset clears occupancy, the pending save and loads register defaults;
// the slot memory needs no clearing.
module sensor_timestamp_matcher #(
  parameter int ENTRIES_PER_SENSOR = stm_pkg::EntriesDefault
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  stm_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_ready,
  output stm_pkg::out_item_t out_item,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [25:0]        cfg_data
);
  logic [19:0] match_window;
  logic [25:0] hold_time;
  logic [1:0]  pano_count;
  logic        save_pending;
  stm_pkg::dp_cmd_t  cmd;
  stm_pkg::dp_stat_t stat;
  stm_pkg::out_item_t res;

  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      match_window <= 20'd50000;
      hold_time    <= 26'd1000000;
      pano_count   <= 2'd0;
    end else if (cfg_valid) begin
      case (cfg_index)
        stm_pkg::REG_WINDOW: match_window <= cfg_data[19:0];
        stm_pkg::REG_HOLD:   hold_time    <= cfg_data;
        stm_pkg::REG_PANO:   pano_count   <= (cfg_data[1:0] == 2'd3) ? 2'd2 : cfg_data[1:0];
        default: ;
      endcase
    end
  end

  stm_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_ready,
    .in_req(in_item.req_type),
    .out_valid, .out_ready, .cmd, .stat, .save_pending
  );

  stm_datapath #(
    .ENTRIES_PER_SENSOR(ENTRIES_PER_SENSOR)
  ) u_dp (
    .clk, .rst, .cmd, .stat,
    .item(in_item), .match_window, .hold_time, .pano_count, .save_pending,
    .result(res)
  );

  // result register: loads whenever nothing is held
  always_ff @(posedge clk) begin
    if (!out_valid || out_ready) out_item <= res;
  end

  a_out_held: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid) else $error("result dropped");
  a_pano_range: assert property (@(posedge clk) disable iff (rst)
    pano_count != 2'd3) else $error("pano count out of range");
  a_hold_result: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(out_item)) else $error("result changed");

endmodule

// ===== verif/tb_sensor_timestamp_matcher.sv =====
// Testbench for sensor_timestamp_matcher: directed table plus random traffic,
// every sync tick result checked against a behavioral predictor. Needs stm_pkg.
`timescale 1ns / 100ps

module tb_sensor_timestamp_matcher;

  localparam int Slots = 16;
  localparam int TickLat = 4 * (5 * Slots + 3) + 20;
  localparam int WatchLimit = 20000;

  logic clk, rst;
  logic in_valid, in_ready, out_valid, out_ready;
  logic cfg_valid, cfg_ready;
  logic [1:0] cfg_index;
  logic [25:0] cfg_data;
  stm_pkg::in_item_t in_item;
  stm_pkg::out_item_t out_item;

  sensor_timestamp_matcher dut (
    .clk, .rst, .in_valid, .in_ready, .in_item, .out_valid, .out_ready,
    .out_item, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  // predictor state
  logic [39:0] st_time [5][Slots];
  logic st_valid [5][Slots];
  logic st_used [5][Slots];
  logic save_flag;
  logic [19:0] win_us;
  logic [25:0] hold_us;
  logic [1:0] pano_cnt;

  stm_pkg::out_item_t match_q[$];
  int errors, mism;
  int idle_cycles;
  bit calm;
  bit quiet_out;

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  function automatic bit store_on(int s);
    if (s == 2) return pano_cnt >= 1;
    if (s == 3) return pano_cnt >= 2;
    return 1;
  endfunction

  task automatic predict_reset();
    for (int s = 0; s < 5; s++)
      for (int i = 0; i < Slots; i++) begin
        st_used[s][i] = 0;
        st_time[s][i] = '0;
        st_valid[s][i] = 0;
      end
    save_flag = 0;
    win_us = 20'd50000;
    hold_us = 26'd1000000;
    pano_cnt = 0;
  endtask

  task automatic predict_cfg(logic [1:0] idx, logic [25:0] d);
    case (idx)
      stm_pkg::REG_WINDOW: win_us = d[19:0];
      stm_pkg::REG_HOLD: hold_us = d;
      stm_pkg::REG_PANO: pano_cnt = (d[1:0] == 2'd3) ? 2'd2 : d[1:0];
      default: ;
    endcase
  endtask

  // compute the outcome of one accepted item; ticks queue an expectation
  task automatic predict_item(stm_pkg::in_item_t it);
    logic [39:0] cut, mt, d, bd [5], bt [5];
    bit mf, any, fnd [5];
    stm_pkg::out_item_t r;
    int sid;
    sid = int'(it.sensor_id);
    r = '0;
    if (it.req_type == stm_pkg::REQ_ARRIVAL) begin
      if (sid < 5 && store_on(sid))
        for (int i = 0; i < Slots; i++)
          if (!st_used[sid][i]) begin
            st_used[sid][i] = 1;
            st_time[sid][i] = it.frame_time;
            st_valid[sid][i] = it.frame_valid;
            break;
          end
    end else if (it.req_type == stm_pkg::REQ_SAVE) begin
      save_flag = 1;
    end else if (it.req_type == stm_pkg::REQ_TICK) begin
      if (it.now_time >= {14'd0, hold_us}) begin
        cut = it.now_time - {14'd0, hold_us};
        for (int s = 0; s < 5; s++)
          if (store_on(s))
            for (int i = 0; i < Slots; i++)
              if (st_used[s][i] && st_time[s][i] < cut) st_used[s][i] = 0;
      end
      mf = 0; mt = '0; any = 0;
      for (int i = 0; i < Slots; i++)
        if (st_used[0][i] && (!mf || st_time[0][i] > mt)) begin
          mt = st_time[0][i];
          mf = 1;
        end
      if (mf) begin
        for (int s = 1; s < 5; s++) begin
          fnd[s] = 0; bd[s] = '0; bt[s] = '0;
          if (!store_on(s)) continue;
          for (int i = 0; i < Slots; i++) begin
            if (!st_used[s][i]) continue;
            if (s != 1 && !st_valid[s][i]) continue;
            d = (st_time[s][i] >= mt) ? st_time[s][i] - mt : mt - st_time[s][i];
            if (d <= {20'd0, win_us} && (!fnd[s] || d < bd[s])) begin
              fnd[s] = 1; bd[s] = d; bt[s] = st_time[s][i];
            end
          end
          if (fnd[s]) any = 1;
        end
        r.master_found = 1;
        r.master_time = mt;
        r.any_match = any;
        if (any) begin
          r.save_now = save_flag;
          save_flag = 0;
          for (int i = 0; i < Slots; i++)
            if (st_used[0][i] && st_time[0][i] <= mt) st_used[0][i] = 0;
          for (int s = 1; s < 5; s++)
            if (fnd[s])
              for (int i = 0; i < Slots; i++)
                if (st_used[s][i] && st_time[s][i] <= bt[s]) st_used[s][i] = 0;
        end
        r.cam_a_found = fnd[1]; r.cam_a_time = fnd[1] ? bt[1] : '0;
        r.pano0_found = fnd[2]; r.pano0_time = fnd[2] ? bt[2] : '0;
        r.pano1_found = fnd[3]; r.pano1_time = fnd[3] ? bt[3] : '0;
        r.cam_b_found = fnd[4]; r.cam_b_time = fnd[4] ? bt[4] : '0;
      end
      match_q = {match_q, r};
    end
  endtask

  // result checker and receiver stalls
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (match_q.size() == 0) begin
          errors++;
          if (mism < 10) $display("unexpected result %h", out_item);
          mism++;
        end else begin
          automatic stm_pkg::out_item_t e = match_q.pop_front();
          if (out_item !== e) begin
            errors++;
            if (mism < 10) $display("mismatch exp %h got %h", e, out_item);
            mism++;
          end
        end
      end
      out_ready <= (calm || quiet_out) ? 1'b1 : ($urandom_range(0, 99) >= 12);
    end
  end

  // watchdog on accepted traffic
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)
        || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WatchLimit) begin
        $display("tb_sensor_timestamp_matcher NOT OK");
        $finish;
      end
    end
  end

  // valid stays high after an accept; callers drop it before any pause
  task automatic send_item(stm_pkg::in_item_t it);
    while (!calm && $urandom_range(0, 99) < 12) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_item(it);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [25:0] d);
    // drain, then let the block finish its last sweep
    in_valid <= 1'b0;
    while (match_q.size() != 0) @(posedge clk);
    repeat (TickLat) @(posedge clk);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= d;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    predict_cfg(idx, d);
    cfg_valid <= 0;
  endtask

  function automatic stm_pkg::in_item_t mk(logic [1:0] rq, logic [2:0] sid, logic [39:0] ft,
                                           logic fv, logic [39:0] nt);
    stm_pkg::in_item_t it;
    it.req_type = rq; it.sensor_id = sid; it.frame_time = ft;
    it.frame_valid = fv; it.now_time = nt;
    return it;
  endfunction

  function automatic logic [39:0] rnd40();
    return 40'({$urandom(), $urandom()});
  endfunction

  stm_pkg::in_item_t dir_tab[$];
  stm_pkg::out_item_t dir_exp[$];
  bit dir_has[$];

  task automatic add_row(stm_pkg::in_item_t it, stm_pkg::out_item_t ex, bit has);
    dir_tab = {dir_tab, it};
    dir_exp = {dir_exp, ex};
    dir_has = {dir_has, has};
  endtask

  initial begin
    automatic logic [39:0] base, now;
    automatic stm_pkg::out_item_t e;
    automatic stm_pkg::in_item_t it;
    automatic int k;
    rst = 1; in_valid = 0; in_item = '0;
    cfg_valid = 0; cfg_index = stm_pkg::REG_WINDOW; cfg_data = '0;
    calm = 0; quiet_out = 0; errors = 0; mism = 0;
    predict_reset();
    repeat (11) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed table; expected value typed in where obvious
    e = '0;
    add_row(mk(stm_pkg::REQ_TICK, stm_pkg::SID_MASTER, '0, 1'b0, '0), e, 1'b1);
    add_row(mk(stm_pkg::REQ_SAVE, stm_pkg::SID_MASTER, '0, 1'b0, '0), e, 1'b0);
    add_row(mk(stm_pkg::REQ_SAVE, stm_pkg::SID_MASTER, '0, 1'b0, '0), e, 1'b0);
    add_row(mk(stm_pkg::REQ_ARRIVAL, stm_pkg::SID_MASTER, 40'd1000, 1'b1, '0), e, 1'b0);
    add_row(mk(stm_pkg::REQ_ARRIVAL, stm_pkg::SID_CAM_A, 40'd1010, 1'b0, '0), e, 1'b0);
    add_row(mk(stm_pkg::REQ_ARRIVAL, stm_pkg::SID_CAM_B, 40'd990, 1'b0, '0), e, 1'b0);
    add_row(mk(stm_pkg::REQ_ARRIVAL, stm_pkg::SID_PANO0, 40'd1000, 1'b1, '0), e, 1'b0);
    add_row(mk(stm_pkg::REQ_ARRIVAL, 3'd7, 40'd5, 1'b1, '0), e, 1'b0);
    add_row(mk(2'd3, 3'd7, '1, 1'b1, '1), e, 1'b0);
    e.master_found = 1; e.master_time = 40'd1000; e.any_match = 1; e.save_now = 1;
    e.cam_a_found = 1; e.cam_a_time = 40'd1010;
    add_row(mk(stm_pkg::REQ_TICK, stm_pkg::SID_MASTER, '0, 1'b0, 40'd5), e, 1'b1);
    add_row(mk(stm_pkg::REQ_ARRIVAL, stm_pkg::SID_MASTER, '1, 1'b1, '0), e, 1'b0);
    add_row(mk(stm_pkg::REQ_ARRIVAL, stm_pkg::SID_CAM_B, '1, 1'b1, '0), e, 1'b0);
    add_row(mk(stm_pkg::REQ_ARRIVAL, stm_pkg::SID_CAM_B, 40'hFF_FFFF_FFF0, 1'b1, '0),
            e, 1'b0);
    add_row(mk(stm_pkg::REQ_TICK, stm_pkg::SID_CAM_B, '0, 1'b1, '1), e, 1'b0);
    for (int i = 0; i < 17; i++) begin
      add_row(mk(stm_pkg::REQ_ARRIVAL, stm_pkg::SID_CAM_A, 40'd100 + 40'(i), 1'b1, '0),
              e, 1'b0);
    end
    add_row(mk(stm_pkg::REQ_TICK, stm_pkg::SID_MASTER, '0, 1'b0, 40'd200), e, 1'b0);

    for (int i = 0; i < dir_tab.size(); i++) begin
      send_item(dir_tab[i]);
      if (dir_has[i] && match_q.size() != 0 && match_q[$] !== dir_exp[i]) begin
        errors++;
        if (mism < 10) $display("row %0d: predictor %h table %h", i, match_q[$], dir_exp[i]);
        mism++;
      end
    end

    // settings: defaults then sweeps through extremes
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: begin write_reg(stm_pkg::REG_PANO, 26'd2); end
        1: begin write_reg(stm_pkg::REG_WINDOW, 26'd0); write_reg(stm_pkg::REG_HOLD, 26'd0); end
        2: begin write_reg(stm_pkg::REG_WINDOW, 26'd1000000);
                 write_reg(stm_pkg::REG_HOLD, 26'd60000000);
                 write_reg(stm_pkg::REG_PANO, 26'd1); end
        3: begin write_reg(stm_pkg::REG_PANO, 26'd3);
                 write_reg(stm_pkg::REG_WINDOW, 26'hFFFFF); end
        4: begin write_reg(stm_pkg::REG_HOLD, 26'h3FFFFFF);
                 write_reg(stm_pkg::REG_PANO, 26'd0); end
        5: begin write_reg(stm_pkg::REG_WINDOW, 26'd500);
                 write_reg(stm_pkg::REG_HOLD, 26'd20000);
                 write_reg(stm_pkg::REG_PANO, 26'd2); end
        6: begin write_reg(stm_pkg::REG_WINDOW, 26'd50000);
                 write_reg(stm_pkg::REG_HOLD, 26'd1000000); end
        default: write_reg(stm_pkg::REG_WINDOW, 26'($urandom_range(0, 1000000)));
      endcase
      calm = (ph == 4);
      quiet_out = (ph == 4);
      base = (ph == 7) ? rnd40() : 40'd2000000 + 40'(ph) * 40'd100000000;
      now = base;
      for (int n = 0; n < 125; n++) begin
        k = $urandom_range(0, 99);
        now = now + 40'($urandom_range(0, 40000));
        if (k < 8) begin
          // noise: any field value
          it = mk(2'($urandom_range(0, 3)), 3'($urandom_range(0, 7)), rnd40(),
                  1'($urandom_range(0, 1)), rnd40());
          if (it.req_type == stm_pkg::REQ_TICK && $urandom_range(0, 1) != 0)
            it.now_time = now;
        end else if (k < 60) begin
          it = mk(stm_pkg::REQ_ARRIVAL, 3'($urandom_range(0, 4)),
                  now - 40'd60000 + 40'($urandom_range(0, 120000)),
                  $urandom_range(0, 3) != 0, rnd40());
        end else if (k < 68) begin
          it = mk(stm_pkg::REQ_SAVE, 3'($urandom_range(0, 7)), rnd40(),
                  1'($urandom_range(0, 1)), rnd40());
        end else begin
          it = mk(stm_pkg::REQ_TICK, 3'($urandom_range(0, 7)), rnd40(),
                  1'($urandom_range(0, 1)), now);
        end
        send_item(it);
      end
    end

    in_valid <= 1'b0;
    while (match_q.size() != 0) @(posedge clk);
    repeat (TickLat) @(posedge clk);
    if (errors == 0 && match_q.size() == 0) begin
      $display("tb_sensor_timestamp_matcher OK");
    end else begin
      $display("tb_sensor_timestamp_matcher NOT OK");
    end
    $finish;
  end

endmodule
